>>> rtl/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// lmbs_pkg
// Shared types and constants for the LED matrix bar-graph scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package lmbs_pkg;

  // Default matrix geometry
  localparam int ROWS_DEFAULT = 3;
  localparam int COLS_DEFAULT = 3;

  // Command codes on the input word
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Chain select codes on the output word
  localparam logic CHAIN_COL = 1'b0;
  localparam logic CHAIN_ROW = 1'b1;

  // Scan sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/led_matrix_bar_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_bar_scanner
// Bar-graph driver for a multiplexed LED matrix fed by two serial chains.
// ----------------------------------------------------------------------------
// A scan word puts its first output word out in the cycle after it is accepted.
// A scan word gives COLS + ROWS output words, one per cycle while bit_ready is high,
//   through a single output shift register; the next input word is taken in the
//   cycle the last bit leaves, so scans can follow back to back.
// A load word gives no output.
// Reset: synchronous, clears the sequencer, the scan column and all column
//   patterns (matrix dark).
`default_nettype none

module led_matrix_bar_scanner #(
  parameter int ROWS = lmbs_pkg::ROWS_DEFAULT,
  parameter int COLS = lmbs_pkg::COLS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input words
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire logic       command,
  input  wire logic [1:0] column_index,
  input  wire logic [1:0] bar_height,
  // output words
  output logic            bit_valid,
  input  wire logic       bit_ready,
  output logic            chain_select,
  output logic            serial_bit,
  output logic            last_bit
);

  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int SW = COLS + ROWS;
  localparam int NW = $clog2(SW + 1);

  lmbs_pkg::state_t state, state_next;

  logic [ROWS-1:0] column_pattern [COLS];
  logic [CW-1:0]   scan_column;
  logic [SW-1:0]   shift_data;
  logic [NW-1:0]   remaining;

  logic            cmd_accept;
  logic            scan_accept;
  logic            load_accept;
  logic            bit_accept;
  logic [ROWS-1:0] load_mask;
  logic [COLS-1:0] sel_onehot;
  logic [CW-1:0]   wr_idx;

  assign cmd_accept  = cmd_valid && cmd_ready;
  assign scan_accept = cmd_accept && (command == lmbs_pkg::CMD_SCAN);
  assign load_accept = cmd_accept && (command == lmbs_pkg::CMD_LOAD);
  assign bit_accept  = bit_valid && bit_ready;
  assign wr_idx      = CW'(column_index);

  // Bar mask: row r lit when it sits within height rows of the bottom;
  // heights past the row count light every row
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      load_mask[r] = ((r + int'(bar_height)) >= ROWS);
    end
  end

  // One-hot column select for the current scan column
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      sel_onehot[c] = (scan_column == CW'(c));
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lmbs_pkg::ST_IDLE: begin
        if (scan_accept) state_next = lmbs_pkg::ST_SHIFT;
      end
      lmbs_pkg::ST_SHIFT: begin
        if (bit_accept && last_bit) begin
          state_next = scan_accept ? lmbs_pkg::ST_SHIFT : lmbs_pkg::ST_IDLE;
        end
      end
      default: state_next = lmbs_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs: take a new word when idle or while the last bit leaves
  always_comb begin
    case (state)
      lmbs_pkg::ST_IDLE: begin
        bit_valid = 1'b0;
        cmd_ready = 1'b1;
      end
      lmbs_pkg::ST_SHIFT: begin
        bit_valid = 1'b1;
        cmd_ready = bit_ready && last_bit;
      end
      default: begin
        bit_valid = 1'b0;
        cmd_ready = 1'b0;
      end
    endcase
  end

  // Output word comes straight from registers
  assign serial_bit   = shift_data[SW-1];
  assign chain_select = (remaining <= NW'(ROWS)) ? lmbs_pkg::CHAIN_ROW
                                                 : lmbs_pkg::CHAIN_COL;
  assign last_bit     = (remaining == NW'(1));

  // Sequencer state and scan column
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lmbs_pkg::ST_IDLE;
      scan_column <= '0;
      remaining   <= '0;
    end else begin
      state <= state_next;
      if (scan_accept) begin
        remaining   <= NW'(SW);
        scan_column <= (scan_column == CW'(COLS - 1)) ? '0 : scan_column + 1'b1;
      end else if (bit_accept) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  // Output shift register: column select bits, then inverted row bits
  always_ff @(posedge clk) begin
    if (scan_accept) begin
      shift_data <= {sel_onehot, ~column_pattern[scan_column]};
    end else if (bit_accept) begin
      shift_data <= {shift_data[SW-2:0], 1'b0};
    end
  end

  // Column pattern store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLS; c++) begin
        column_pattern[c] <= '0;
      end
    end else if (load_accept && (int'(column_index) < COLS)) begin
      column_pattern[wr_idx] <= load_mask;
    end
  end

  // Checks
  a_last_on_row_chain: assert property (@(posedge clk) disable iff (rst)
    bit_valid && last_bit |-> chain_select == lmbs_pkg::CHAIN_ROW)
    else $error("last bit outside row chain");

  a_scan_starts_col: assert property (@(posedge clk) disable iff (rst)
    scan_accept |=> bit_valid && chain_select == lmbs_pkg::CHAIN_COL
                    && remaining == NW'(SW))
    else $error("scan did not start on column chain");

  a_drain_to_idle: assert property (@(posedge clk) disable iff (rst)
    bit_accept && last_bit && !scan_accept |=> !bit_valid)
    else $error("output still valid after last bit");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    int'(scan_column) < COLS)
    else $error("scan column out of range");

endmodule

`default_nettype wire
